// ===== hdl/stpg_pkg.sv =====
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared types and constants of the sensor test pattern generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

   localparam int NOW_W   = 32;
   localparam int LEVEL_W = 16;
   localparam int DELTA_W = 17;

   localparam logic [2:0] MODE_DISC  = 3'd0;
   localparam logic [2:0] MODE_FILL  = 3'd1;
   localparam logic [2:0] MODE_DRAIN = 3'd2;
   localparam logic [2:0] MODE_SPIKE = 3'd3;
   localparam logic [2:0] MODE_FLUCT = 3'd4;
   localparam logic [2:0] MODE_STUCK = 3'd5;

   localparam logic [1:0] CSR_SIM_MODE    = 2'd0;
   localparam logic [1:0] CSR_DISC_THRESH = 2'd1;
   localparam logic [1:0] CSR_SPIKE_DELTA = 2'd2;
   localparam logic [1:0] CSR_FLUCT_DELTA = 2'd3;

   localparam logic [2:0]  RST_SIM_MODE    = MODE_DISC;
   localparam logic [15:0] RST_DISC_THRESH = 16'd30000;
   localparam logic [13:0] RST_SPIKE_DELTA = 14'd10000;
   localparam logic [14:0] RST_FLUCT_DELTA = 15'd5000;

   localparam logic [15:0] FILL_CAP    = 16'd45000;
   localparam logic [15:0] DRAIN_FLOOR = 16'd32000;
   localparam logic [15:0] SPIKE_LOW   = 16'd32000;
   localparam logic [15:0] SPIKE_HIGH  = 16'd48000;
   localparam logic [15:0] BASELINE    = 16'd36000;
   localparam logic [15:0] STUCK_START = 16'd37000;
   localparam logic [15:0] FLUCT_START = 16'd38000;
   localparam logic [15:0] DISC_OFFSET = 16'd500;
   localparam logic [15:0] DRIFT_STEP  = 16'd200;
   localparam logic [15:0] FLUCT_BIAS  = 16'd1000;

   localparam logic [DELTA_W-1:0] ELAPSED_MAX = 17'h1FFFF;

   typedef struct packed {
      logic [2:0]  sim_mode;
      logic [15:0] disconnect_threshold;
      logic [13:0] spike_delta;
      logic [14:0] fluct_delta;
   } cfg_type;

   typedef struct packed {
      logic               init;
      logic [DELTA_W-1:0] delta;
   } ramp_type;

   typedef struct packed {
      logic spike_win;
      logic spike_up;
      logic fluct_hi;
   } phase_type;

endpackage

// ===== hdl/sensor_test_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// sensor_test_pattern_generator
// Synthetic raw level-probe readings, one per read transaction.
// ----------------------------------------------------------------------------
// A read transaction carries the current millisecond time and returns one
// 16-bit raw value. A new read is taken every cycle unless a result waits on
// rsp_tready, which holds the whole pipeline. Each result goes through the
// window decode of the time (reciprocal and back-multiplies for now mod
// 24000, then window quotients) and the level register. The user must write
// configuration only while no read is in flight; the block does not enforce it.
module sensor_test_pattern_generator
   import stpg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [NOW_W-1:0]   req_tdata,   // [31:0] now_ms
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [LEVEL_W-1:0] rsp_tdata,   // [15:0] raw_value
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int DEPTH = 5;

   cfg_type            cfg_ff, cfg_in;
   logic [DEPTH-1:0]   vld_ff, vld_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [NOW_W-1:0]   now_ff;
   logic               advance;
   ramp_type           ramp;
   phase_type          flags;

   assign advance    = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIM_MODE:    cfg_in.sim_mode             = csr_wdata[2:0];
            CSR_DISC_THRESH: cfg_in.disconnect_threshold = csr_wdata;
            CSR_SPIKE_DELTA: cfg_in.spike_delta          = csr_wdata[13:0];
            CSR_FLUCT_DELTA: cfg_in.fluct_delta          = csr_wdata[14:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
      vld_in        = vld_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (advance) begin
         vld_in        = {vld_ff[DEPTH-2:0], req_tvalid};
         rsp_tvalid_in = vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sim_mode             <= RST_SIM_MODE;
         cfg_ff.disconnect_threshold <= RST_DISC_THRESH;
         cfg_ff.spike_delta          <= RST_SPIKE_DELTA;
         cfg_ff.fluct_delta          <= RST_FLUCT_DELTA;
         vld_ff                      <= '0;
         rsp_tvalid_ff               <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         now_ff <= req_tdata;
      end
   end

   stpg_ramp u_ramp (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .step        (advance & vld_ff[0]),
      .clear_start (csr_we && (csr_index == CSR_SIM_MODE)),
      .now         (now_ff),
      .ramp        (ramp)
   );

   stpg_phase u_phase (
      .clock  (clock),
      .enable (advance),
      .now    (now_ff),
      .flags  (flags)
   );

   stpg_level u_level (
      .clock  (clock),
      .update (advance & vld_ff[DEPTH-1]),
      .cfg    (cfg_ff),
      .ramp   (ramp),
      .flags  (flags),
      .level  (rsp_tdata)
   );

endmodule

// ===== hdl/stpg_phase.sv =====
// ----------------------------------------------------------------------------
// stpg_phase
// Time-window flags from the millisecond count: now mod 24000 is formed by
// reciprocal multiplication, then the 1200/300/400 ms windows are decoded.
// ----------------------------------------------------------------------------
module stpg_phase
   import stpg_pkg::*;
(
   input  logic             clock,
   input  logic             enable,
   input  logic [NOW_W-1:0] now,
   output phase_type        flags
);

   localparam int LOW_W  = 6;
   localparam int Q_W    = NOW_W - LOW_W;
   localparam int MOD_K  = 35;
   localparam int P1_W   = 53;
   localparam int QUOT_W = 18;
   localparam int P2_W   = 27;
   localparam int R_W    = 15;
   localparam int RP_W   = 32;

   localparam logic [P2_W-1:0] MOD_DIV   = 27'd375;
   // truncated reciprocal: quotient is never high, at most one low
   localparam logic [P2_W-1:0] MOD_RECIP =
      27'((64'd1 << MOD_K) / 64'd375);
   localparam logic [16:0] RECIP_300  = 17'(((64'd1 << 24) + 64'd299) / 64'd300);
   localparam logic [16:0] RECIP_400  = 17'(((64'd1 << 24) + 64'd399) / 64'd400);
   localparam logic [16:0] RECIP_1200 = 17'(((64'd1 << 26) + 64'd1199) / 64'd1200);

   logic [Q_W-1:0]   q1_ff, q2_ff;
   logic [LOW_W-1:0] low1_ff, low2_ff;
   logic [P1_W-1:0]  prod1_ff, prod1_in;
   logic [P2_W-1:0]  prod2_ff, prod2_in;
   logic [R_W-1:0]   rem_ff, rem_in;
   phase_type        flags_ff, flags_in;

   logic [QUOT_W-1:0] quot;
   logic [P2_W-1:0]   diff, diff_adj;
   logic [RP_W-1:0]   p300, p400, p1200;
   logic [4:0]        win_idx;

   always_comb begin
      prod1_in = {27'd0, now[NOW_W-1:LOW_W]} * {26'd0, MOD_RECIP};
      quot     = prod1_ff[P1_W-1:MOD_K];
      prod2_in = {9'd0, quot} * MOD_DIV;
      diff     = {1'b0, q2_ff} - prod2_ff;
      diff_adj = (diff >= MOD_DIV) ? diff - MOD_DIV : diff;
      rem_in   = {diff_adj[8:0], low2_ff};
      p300     = {17'd0, rem_ff} * {15'd0, RECIP_300};
      p400     = {17'd0, rem_ff} * {15'd0, RECIP_400};
      p1200    = {17'd0, rem_ff} * {15'd0, RECIP_1200};
      win_idx  = p1200[30:26];
      flags_in.spike_win = (win_idx == 5'd0) || (win_idx == 5'd5) ||
                           (win_idx == 5'd10) || (win_idx == 5'd15);
      flags_in.spike_up  = ~p300[24];
      flags_in.fluct_hi  = ~p400[24];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q1_ff    <= now[NOW_W-1:LOW_W];
         low1_ff  <= now[LOW_W-1:0];
         prod1_ff <= prod1_in;
         q2_ff    <= q1_ff;
         low2_ff  <= low1_ff;
         prod2_ff <= prod2_in;
         rem_ff   <= rem_in;
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

// ===== hdl/stpg_ramp.sv =====
// ----------------------------------------------------------------------------
// stpg_ramp
// Tracks start-up and the previous read time; yields the ramp step
// floor(3*e/5) with the elapsed time e saturated.
// ----------------------------------------------------------------------------
module stpg_ramp
   import stpg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             step,
   input  logic             clear_start,
   input  logic [NOW_W-1:0] now,
   output ramp_type         ramp
);

   localparam int X_W    = DELTA_W + 2;
   localparam int DIV_K  = 22;
   localparam int PR_W   = 39;
   localparam logic [19:0] RECIP_5 = 20'(((64'd1 << DIV_K) + 64'd4) / 64'd5);

   logic               started_ff, started_in;
   logic [NOW_W-1:0]   last_ff, last_in;
   logic [DELTA_W-1:0] e1_ff, e1_in;
   logic [PR_W-1:0]    prod_ff, prod_in;
   logic [DELTA_W-1:0] d3_ff, d4_ff;
   logic               init1_ff, init2_ff, init3_ff, init4_ff;

   logic [NOW_W-1:0] diff;
   logic [X_W-1:0]   x;

   always_comb begin
      diff = now - last_ff;
      if (!started_ff) begin
         e1_in = '0;
      end else if (diff > {15'd0, ELAPSED_MAX}) begin
         e1_in = ELAPSED_MAX;
      end else begin
         e1_in = diff[DELTA_W-1:0];
      end
      started_in = started_ff;
      last_in    = last_ff;
      if (clear_start) begin
         started_in = 1'b0;
      end else if (step) begin
         started_in = 1'b1;
         last_in    = now;
      end
      x       = {2'b00, e1_ff} + {1'b0, e1_ff, 1'b0};
      prod_in = {20'd0, x} * {19'd0, RECIP_5};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         last_ff    <= '0;
      end else begin
         started_ff <= started_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e1_ff    <= e1_in;
         init1_ff <= ~started_ff;
         prod_ff  <= prod_in;
         init2_ff <= init1_ff;
         d3_ff    <= prod_ff[DIV_K+DELTA_W-1:DIV_K];
         init3_ff <= init2_ff;
         d4_ff    <= d3_ff;
         init4_ff <= init3_ff;
      end
   end

   assign ramp.init  = init4_ff;
   assign ramp.delta = d4_ff;

endmodule

// ===== hdl/stpg_level.sv =====
// ----------------------------------------------------------------------------
// stpg_level
// Level state and per-mode update; the level register is the result data.
// ----------------------------------------------------------------------------
module stpg_level
   import stpg_pkg::*;
(
   input  logic               clock,
   input  logic               update,
   input  cfg_type            cfg,
   input  ramp_type           ramp,
   input  phase_type          flags,
   output logic [LEVEL_W-1:0] level
);

   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] disc, base, start;
   logic [17:0]        fill_sum, drain_lim, fluct_hi;
   logic [15:0]        amp;
   logic signed [17:0] sv;

   always_comb begin
      disc = (cfg.disconnect_threshold >= DISC_OFFSET) ?
             cfg.disconnect_threshold - DISC_OFFSET : '0;
      case (cfg.sim_mode)
         MODE_FILL:  start = DRAIN_FLOOR;
         MODE_DRAIN: start = FILL_CAP;
         MODE_SPIKE: start = BASELINE;
         MODE_FLUCT: start = FLUCT_START;
         MODE_STUCK: start = STUCK_START;
         default:    start = disc;
      endcase
      base = ramp.init ? start : level_ff;

      fill_sum  = {2'b00, base} + {1'b0, ramp.delta};
      drain_lim = {1'b0, ramp.delta} + {2'b00, DRAIN_FLOOR};
      amp       = {1'b0, cfg.fluct_delta} + FLUCT_BIAS;
      fluct_hi  = {2'b00, BASELINE} + {2'b00, amp};
      sv        = flags.spike_up ? $signed({2'b00, base}) + $signed({4'b0, cfg.spike_delta})
                                 : $signed({2'b00, base}) - $signed({4'b0, cfg.spike_delta});

      case (cfg.sim_mode)
         MODE_FILL: begin
            level_in = (fill_sum > {2'b00, FILL_CAP}) ? FILL_CAP : fill_sum[15:0];
         end
         MODE_DRAIN: begin
            level_in = ({2'b00, base} < drain_lim) ? DRAIN_FLOOR
                                                   : base - ramp.delta[15:0];
         end
         MODE_SPIKE: begin
            if (flags.spike_win) begin
               if (sv < $signed({2'b00, SPIKE_LOW})) begin
                  level_in = SPIKE_LOW;
               end else if (sv > $signed({2'b00, SPIKE_HIGH})) begin
                  level_in = SPIKE_HIGH;
               end else begin
                  level_in = sv[15:0];
               end
            end else if (base > BASELINE) begin
               level_in = (base - BASELINE < DRIFT_STEP) ? BASELINE : base - DRIFT_STEP;
            end else if (base < BASELINE) begin
               level_in = (BASELINE - base < DRIFT_STEP) ? BASELINE : base + DRIFT_STEP;
            end else begin
               level_in = base;
            end
         end
         MODE_FLUCT: begin
            if (flags.fluct_hi) begin
               level_in = (fluct_hi > 18'd65535) ? 16'hFFFF : fluct_hi[15:0];
            end else begin
               level_in = (amp >= BASELINE) ? '0 : BASELINE - amp;
            end
         end
         MODE_STUCK: level_in = base;
         default:    level_in = disc;
      endcase
   end

   always_ff @(posedge clock) begin
      if (update) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule
